[hw/rtl/lpht_pkg.sv]
// Shared types and constants for the linear-probing hash table.
package lpht_pkg;

  localparam int KEY_W       = 64;
  localparam int IN_VALUE_W  = 32;
  localparam int SLOT_NUM_W  = 4;
  localparam int TOTAL_W     = 5;
  localparam int MAX_IDX_W   = 12;
  localparam int DIGIT_BITS  = 8;
  localparam int DIGITS      = KEY_W / DIGIT_BITS;
  localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } lpht_cmd_e;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_NEW  = 2'd2,
    ST_FULL = 2'd3
  } lpht_status_e;

  typedef enum logic [1:0] {
    K_LOOKUP = 2'd0,
    K_INSERT = 2'd1,
    K_READ   = 2'd2,
    K_SKIP   = 2'd3
  } lpht_kind_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_PROBE = 2'd2
  } lpht_back_state_e;

  typedef struct packed {
    lpht_kind_e              kind;
    logic [KEY_W-1:0]        key_hash;
    logic [IN_VALUE_W-1:0]   write_value;
    logic [MAX_IDX_W-1:0]    home;
    logic [SLOT_NUM_W-1:0]   slot_number;
  } lpht_item_t;

endpackage

[hw/rtl/lpht_front.sv]
// Front end: accepts input words, classifies them and works out the home slot.
module lpht_front #(
  parameter int SLOTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            cmd_i,
  input  logic [lpht_pkg::KEY_W-1:0]            key_hash_i,
  input  logic [lpht_pkg::IN_VALUE_W-1:0]       write_value_i,
  input  logic [lpht_pkg::SLOT_NUM_W-1:0]       slot_number_i,
  output logic                                  push_valid_o,
  output lpht_pkg::lpht_item_t                  push_item_o,
  input  logic                                  push_ready_i
);
  import lpht_pkg::*;

  localparam int  IDX_W   = $clog2(SLOTS);
  localparam bit  IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

  logic                   stg_v_q, stg_v_d;
  lpht_item_t             stg_q, stg_d;
  logic [KEY_W-1:0]       sh_q, sh_d;
  logic [IDX_W-1:0]       rem_q, rem_d;
  logic [DIGIT_CNT_W-1:0] dig_q, dig_d;
  logic                   done;
  logic                   accept;
  logic [IDX_W-1:0]       rem_next;
  logic [IDX_W:0]         trial;
  lpht_item_t             new_item;

  assign done         = dig_q == DIGIT_CNT_W'(DIGITS);
  assign push_valid_o = stg_v_q && done;
  assign push_item_o  = stg_q;
  assign in_ready_o   = !stg_v_q || (done && push_ready_i);
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    rem_next = rem_q;
    trial    = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      trial = {rem_next, sh_q[KEY_W-1-i]};
      if (trial >= (IDX_W + 1)'(SLOTS)) begin
        trial = trial - (IDX_W + 1)'(SLOTS);
      end
      rem_next = trial[IDX_W-1:0];
    end
  end

  always_comb begin
    new_item             = '0;
    new_item.key_hash    = key_hash_i;
    new_item.write_value = write_value_i;
    new_item.home        = MAX_IDX_W'(key_hash_i[IDX_W-1:0]);
    new_item.slot_number = slot_number_i;
    case (lpht_cmd_e'(cmd_i))
      CMD_LOOKUP: new_item.kind = K_LOOKUP;
      CMD_INSERT: new_item.kind = K_INSERT;
      CMD_READ: begin
        if (int'(slot_number_i) < SLOTS) begin
          new_item.kind = K_READ;
          new_item.home = MAX_IDX_W'(slot_number_i);
        end else begin
          new_item.kind = K_SKIP;
        end
      end
      default: begin
        new_item.kind        = K_SKIP;
        new_item.slot_number = '0;
      end
    endcase
  end

  always_comb begin
    stg_v_d = stg_v_q;
    stg_d   = stg_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    dig_d   = dig_q;
    if (accept) begin
      stg_v_d = 1'b1;
      stg_d   = new_item;
      sh_d    = key_hash_i;
      rem_d   = '0;
      if (IS_POW2 || new_item.kind == K_READ || new_item.kind == K_SKIP) begin
        dig_d = DIGIT_CNT_W'(DIGITS);
      end else begin
        dig_d = '0;
      end
    end else if (push_valid_o && push_ready_i) begin
      stg_v_d = 1'b0;
    end else if (stg_v_q && !done) begin
      rem_d      = rem_next;
      stg_d.home = MAX_IDX_W'(rem_next);
      sh_d       = sh_q << DIGIT_BITS;
      dig_d      = dig_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      dig_q   <= '0;
    end else begin
      stg_v_q <= stg_v_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

endmodule

[hw/rtl/lpht_queue.sv]
// Two-entry queue between the front end and the probe engine.
module lpht_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  lpht_pkg::lpht_item_t  push_item_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output lpht_pkg::lpht_item_t  pop_item_o,
  input  logic                  pop_i
);
  import lpht_pkg::*;

  lpht_item_t          ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_q, rp_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = ent_q[rp_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/lpht_back.sv]
// Probe engine: slot memories, probe walk, writes and the output register.
module lpht_back #(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  lpht_pkg::lpht_item_t                q_item_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [lpht_pkg::IN_VALUE_W-1:0]     read_value_o,
  output logic [lpht_pkg::TOTAL_W-1:0]        entry_total_o,
  output logic [lpht_pkg::SLOT_NUM_W-1:0]     slot_touched_o
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  lpht_back_state_e        state_q, state_d;
  lpht_item_t              cur_q, cur_d;
  logic [IDX_W-1:0]        addr_q, addr_d;
  logic [IDX_W-1:0]        chk_q, chk_d;
  logic [IDX_W-1:0]        seen_q, seen_d;
  logic [IDX_W-1:0]        clr_q;
  logic [TOTAL_W-1:0]      cnt_q, cnt_d;

  logic                    vld_mem [SLOTS];
  logic [KEY_W-1:0]        key_mem [SLOTS];
  logic [VALUE_BITS-1:0]   val_mem [SLOTS];
  logic                    rd_vld_q;
  logic [KEY_W-1:0]        rd_key_q;
  logic [VALUE_BITS-1:0]   rd_val_q;
  logic [IDX_W-1:0]        rd_addr;

  logic                    vld_we, vld_wd, key_we, val_we;
  logic [IDX_W-1:0]        wr_addr, home;
  logic [KEY_W-1:0]        rd_val_wide;

  logic                    out_v_q;
  lpht_status_e            st_q, st_d;
  logic [IN_VALUE_W-1:0]   rv_q, rv_d;
  logic [SLOT_NUM_W-1:0]   tc_q, tc_d;
  logic [TOTAL_W-1:0]      tot_q;
  logic                    out_free, load, start, decide, clr_last;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    wrap_inc = (a == IDX_W'(SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction

  assign out_free     = !out_v_q || out_ready_i;
  assign home         = q_item_i.home[IDX_W-1:0];
  assign clr_last     = clr_q == IDX_W'(SLOTS - 1);
  assign rd_val_wide  = KEY_W'(rd_val_q);
  assign start        = state_q == BK_IDLE && q_valid_i && out_free &&
                        q_item_i.kind != K_SKIP;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: if (clr_last) state_d = BK_IDLE;
      BK_IDLE:  if (start) state_d = BK_PROBE;
      BK_PROBE: if (decide) state_d = BK_IDLE;
      default:  state_d = BK_CLEAR;
    endcase
  end

  always_comb begin
    cur_d   = cur_q;
    addr_d  = addr_q;
    chk_d   = chk_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    rd_addr = addr_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    decide  = 1'b0;
    st_d    = ST_MISS;
    rv_d    = '0;
    tc_d    = '0;
    vld_we  = 1'b0;
    vld_wd  = 1'b0;
    key_we  = 1'b0;
    val_we  = 1'b0;
    wr_addr = chk_q;
    case (state_q)
      BK_CLEAR: begin
        vld_we  = 1'b1;
        wr_addr = clr_q;
      end
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_item_i.kind == K_SKIP) begin
            load = 1'b1;
            tc_d = q_item_i.slot_number;
          end else begin
            cur_d   = q_item_i;
            rd_addr = home;
            chk_d   = home;
            addr_d  = wrap_inc(home);
            seen_d  = '0;
          end
        end
      end
      BK_PROBE: begin
        addr_d = wrap_inc(addr_q);
        chk_d  = addr_q;
        decide = 1'b1;
        if (cur_q.kind == K_READ) begin
          tc_d = SLOT_NUM_W'(chk_q);
          if (rd_vld_q) begin
            st_d = ST_HIT;
            rv_d = rd_val_wide[IN_VALUE_W-1:0];
          end
        end else if (!rd_vld_q) begin
          if (cur_q.kind == K_INSERT) begin
            vld_we = 1'b1;
            vld_wd = 1'b1;
            key_we = 1'b1;
            val_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
            st_d   = ST_NEW;
            tc_d   = SLOT_NUM_W'(chk_q);
          end
        end else if (rd_key_q == cur_q.key_hash) begin
          st_d = ST_HIT;
          tc_d = SLOT_NUM_W'(chk_q);
          if (cur_q.kind == K_INSERT) begin
            val_we = 1'b1;
          end else begin
            rv_d = rd_val_wide[IN_VALUE_W-1:0];
          end
        end else if (seen_q == IDX_W'(SLOTS - 1)) begin
          st_d = (cur_q.kind == K_INSERT) ? ST_FULL : ST_MISS;
        end else begin
          decide = 1'b0;
          seen_d = seen_q + 1'b1;
        end
        load = decide;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_mem[rd_addr];
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
    if (vld_we) begin
      vld_mem[wr_addr] <= vld_wd;
    end
    if (key_we) begin
      key_mem[wr_addr] <= cur_q.key_hash;
    end
    if (val_we) begin
      val_mem[wr_addr] <= VALUE_BITS'(cur_q.write_value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == BK_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    addr_q <= addr_d;
    chk_q  <= chk_d;
    seen_q <= seen_d;
    if (load) begin
      st_q  <= st_d;
      rv_q  <= rv_d;
      tc_q  <= tc_d;
      tot_q <= cnt_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = st_q;
  assign read_value_o   = rv_q;
  assign entry_total_o  = tot_q;
  assign slot_touched_o = tc_q;

endmodule

[hw/rtl/linear_probe_hash_table.sv]
// Top level of the linear-probing hash table.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word: cmd_i selects lookup by
//   key_hash_i, insert or update with write_value_i, or read of slot_number_i.
//   Output channel (out_valid_o/out_ready_i) returns one word per input word, in
//   order: status_o, read_value_o, entry_total_o and slot_touched_o.
//   The probe engine takes one word at a time and reads one slot per cycle from
//   the slot memories, probing one slot for a slot read and up to SLOTS when the
//   table is near full. A word passes the front-end register, the queue, the
//   probe walk and the output register. When SLOTS is not a power of two, the
//   home slot is reduced 8 key bits per cycle in the front end, which takes no new
//   word until it is done; this overlaps the probe walk of earlier words.
//   After reset the table is cleared one slot per cycle; input words are queued
//   meanwhile but no probe starts until the pass is done.
//   When the receiver stalls, the result is held in the output register, the
//   engine waits before starting the next word, and the front end and its
//   two-entry queue keep accepting input until they fill up.
module linear_probe_hash_table #(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [lpht_pkg::KEY_W-1:0]          key_hash_i,
  input  logic [lpht_pkg::IN_VALUE_W-1:0]     write_value_i,
  input  logic [lpht_pkg::SLOT_NUM_W-1:0]     slot_number_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [lpht_pkg::IN_VALUE_W-1:0]     read_value_o,
  output logic [lpht_pkg::TOTAL_W-1:0]        entry_total_o,
  output logic [lpht_pkg::SLOT_NUM_W-1:0]     slot_touched_o
);
  import lpht_pkg::*;

  logic       push_valid, push_ready, q_valid, q_pop;
  lpht_item_t push_item, q_item;

  lpht_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .key_hash_i    (key_hash_i),
    .write_value_i (write_value_i),
    .slot_number_i (slot_number_i),
    .push_valid_o  (push_valid),
    .push_item_o   (push_item),
    .push_ready_i  (push_ready)
  );

  lpht_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_i        (q_pop)
  );

  lpht_back #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .entry_total_o  (entry_total_o),
    .slot_touched_o (slot_touched_o)
  );

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> read_value_o == '0 && slot_touched_o == '0)
    else $error("full result carries data");

  a_new_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NEW |-> entry_total_o != '0)
    else $error("new entry with zero total");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_MISS |-> read_value_o == '0)
    else $error("miss returns a value");

endmodule

[bench/testbench.sv]
// Self-checking bench for the linear-probing hash table: random and directed words, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int TBL_SLOTS  = 16;
  localparam int IDLE_PCT   = 9;
  localparam int QUIET_LO   = 1000;
  localparam int QUIET_HI   = 1800;
  localparam int HOLD_AT    = 100;
  localparam int HOLD_LEN   = 300;
  localparam int DOG_LIMIT  = 2000;
  localparam int TAIL_WAIT  = 40;
  localparam int RAND_WORDS = 330;

  typedef struct packed {
    lpht_cmd_e               cmd;
    logic [KEY_W-1:0]        key;
    logic [IN_VALUE_W-1:0]   wval;
    logic [SLOT_NUM_W-1:0]   snum;
  } tbl_req_t;

  typedef struct packed {
    lpht_status_e            status;
    logic [IN_VALUE_W-1:0]   rval;
    logic [TOTAL_W-1:0]      total;
    logic [SLOT_NUM_W-1:0]   touched;
  } tbl_resp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic     in_valid  = 1'b0;
  logic     out_ready = 1'b0;
  tbl_req_t cur_req   = '0;

  logic                  in_ready;
  logic                  out_valid;
  logic [1:0]            status;
  logic [IN_VALUE_W-1:0] read_value;
  logic [TOTAL_W-1:0]    entry_total;
  logic [SLOT_NUM_W-1:0] slot_touched;

  tbl_req_t  pending_words[$];
  tbl_resp_t expected_resps[$];
  logic [KEY_W-1:0] known_keys[$];

  bit                    tbl_used[TBL_SLOTS];
  logic [KEY_W-1:0]      tbl_key[TBL_SLOTS];
  logic [IN_VALUE_W-1:0] tbl_val[TBL_SLOTS];
  logic [TOTAL_W-1:0]    tbl_count = '0;

  int cyc          = 0;
  int mism_count   = 0;
  int resps_seen   = 0;
  int hold_left    = 0;
  bit held_once    = 1'b0;
  int dog_count    = 0;

  always #4 clk_i = ~clk_i;

  linear_probe_hash_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cur_req.cmd),
    .key_hash_i     (cur_req.key),
    .write_value_i  (cur_req.wval),
    .slot_number_i  (cur_req.snum),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .read_value_o   (read_value),
    .entry_total_o  (entry_total),
    .slot_touched_o (slot_touched)
  );

  function automatic tbl_resp_t table_apply(tbl_req_t r);
    tbl_resp_t res;
    int        pos;
    int        found;
    bit        empty;
    res.status  = ST_MISS;
    res.rval    = '0;
    res.touched = '0;
    found = -1;
    empty = 1'b0;
    pos   = int'(r.key[3:0]);
    for (int n = 0; n < TBL_SLOTS; n++) begin
      if (found < 0) begin
        if (!tbl_used[pos]) begin
          found = pos;
          empty = 1'b1;
        end else if (tbl_key[pos] == r.key) begin
          found = pos;
        end else begin
          pos = (pos + 1) % TBL_SLOTS;
        end
      end
    end
    case (r.cmd)
      CMD_LOOKUP: begin
        if (found >= 0 && !empty) begin
          res.status  = ST_HIT;
          res.rval    = tbl_val[found];
          res.touched = found[SLOT_NUM_W-1:0];
        end
      end
      CMD_INSERT: begin
        if (found < 0) begin
          res.status = ST_FULL;
        end else begin
          if (empty) begin
            tbl_used[found] = 1'b1;
            tbl_key[found]  = r.key;
            tbl_count       = tbl_count + 1'b1;
            res.status      = ST_NEW;
          end else begin
            res.status = ST_HIT;
          end
          tbl_val[found] = r.wval;
          res.touched    = found[SLOT_NUM_W-1:0];
        end
      end
      CMD_READ: begin
        res.touched = r.snum;
        if (tbl_used[r.snum]) begin
          res.status = ST_HIT;
          res.rval   = tbl_val[r.snum];
        end
      end
      default: ;
    endcase
    res.total = tbl_count;
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) k[3:0] = 4'($urandom_range(12, 15));
    return k;
  endfunction

  function automatic logic [IN_VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic add_word(lpht_cmd_e c, logic [KEY_W-1:0] k, logic [IN_VALUE_W-1:0] v,
                          logic [SLOT_NUM_W-1:0] s);
    tbl_req_t w;
    w.cmd  = c;
    w.key  = k;
    w.wval = v;
    w.snum = s;
    if (c == CMD_INSERT) known_keys.push_back(k);
    pending_words.push_back(w);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      mism_count++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (in_valid && in_ready) expected_resps.push_back(table_apply(cur_req));
      if (!(in_valid && !in_ready)) begin
        if (pending_words.size() > 0 &&
            ((cyc >= QUIET_LO && cyc < QUIET_HI) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tbl_resp_t exp_r;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        resps_seen++;
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected word, status %0d value %0h", $realtime, status, read_value);
          mism_count++;
        end else begin
          exp_r = expected_resps.pop_front();
          check_field("status", 64'(exp_r.status), 64'(status));
          check_field("read_value", 64'(exp_r.rval), 64'(read_value));
          check_field("entry_total", 64'(exp_r.total), 64'(entry_total));
          check_field("slot_touched", 64'(exp_r.touched), 64'(slot_touched));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (resps_seen >= HOLD_AT && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (cyc >= QUIET_LO && cyc < QUIET_HI) || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        dog_count <= 0;
      end else if (dog_count >= DOG_LIMIT) begin
        $display("%0t: watchdog timeout", $realtime);
        $display("Mismatches found");
        $finish;
      end else begin
        dog_count <= dog_count + 1;
      end
    end
  end

  initial begin
    int               r;
    logic [KEY_W-1:0] k;

    // empty table, wrap-around, update, key and value extremes
    add_word(CMD_LOOKUP, '0, $urandom, 4'($urandom));
    add_word(CMD_READ, {$urandom, $urandom}, $urandom, 4'd0);
    add_word(CMD_NONE, '1, '1, 4'hf);
    add_word(CMD_INSERT, '1, '1, 4'($urandom));
    add_word(CMD_INSERT, 64'h0123_4567_89ab_cdef, '0, 4'($urandom));
    add_word(CMD_LOOKUP, 64'h0123_4567_89ab_cdef, $urandom, 4'($urandom));
    add_word(CMD_LOOKUP, '1, $urandom, 4'($urandom));
    add_word(CMD_INSERT, '1, 32'h1234_5678, 4'($urandom));
    add_word(CMD_READ, {$urandom, $urandom}, $urandom, 4'hf);
    add_word(CMD_READ, {$urandom, $urandom}, $urandom, 4'h0);
    add_word(CMD_LOOKUP, 64'h8000_0000_0000_000f, $urandom, 4'($urandom));
    add_word(CMD_INSERT, '0, 32'hdead_beef, 4'($urandom));
    add_word(CMD_LOOKUP, '0, $urandom, 4'($urandom));
    add_word(CMD_READ, {$urandom, $urandom}, $urandom, 4'd1);
    add_word(CMD_READ, {$urandom, $urandom}, $urandom, 4'd14);
    add_word(CMD_INSERT, 64'h0123_4567_89ab_cdef, 32'h8000_0001, 4'($urandom));
    add_word(CMD_NONE, '0, '0, 4'h0);

    for (int i = 0; i < RAND_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        add_word(CMD_NONE, {$urandom, $urandom}, $urandom, 4'($urandom));
      end else if (r < 20) begin
        add_word(CMD_READ, {$urandom, $urandom}, $urandom, 4'($urandom));
      end else if (r < 50) begin
        if (known_keys.size() > 0 && $urandom_range(0, 9) < 7)
          k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else
          k = fresh_key();
        add_word(CMD_LOOKUP, k, $urandom, 4'($urandom));
      end else begin
        if (known_keys.size() > 0 && $urandom_range(0, 99) >= 8)
          k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else
          k = fresh_key();
        add_word(CMD_INSERT, k, pick_value(), 4'($urandom));
      end
    end

    // fill to capacity, then drops, misses on a full table, slot reads and lookups of inserted keys
    for (int i = 0; i < 20; i++) add_word(CMD_INSERT, fresh_key(), pick_value(), 4'($urandom));
    for (int i = 0; i < 6; i++) add_word(CMD_LOOKUP, fresh_key(), $urandom, 4'($urandom));
    for (int i = 0; i < TBL_SLOTS; i++)
      add_word(CMD_READ, {$urandom, $urandom}, $urandom, 4'(i));
    for (int i = 0; i < 10; i++)
      add_word(CMD_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)],
               $urandom, 4'($urandom));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || in_valid) @(negedge clk_i);
    while (expected_resps.size() > 0) @(negedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (mism_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_front.sv
hw/rtl/lpht_queue.sv
hw/rtl/lpht_back.sv
hw/rtl/linear_probe_hash_table.sv
bench/testbench.sv
